// ===== rtl/bfd_pkg.sv =====
`default_nettype none

package bfd_pkg;

	// Field and datapath widths
	localparam int DELTA_W  = 16;
	localparam int MAG_W    = 16;
	localparam int Q_SHIFT  = 14;
	localparam int RAT_W    = Q_SHIFT + 1;
	localparam int ANG_W    = 16;
	localparam int K2_W     = 12;
	localparam int PROD1_W  = RAT_W + K2_W;
	localparam int PROD2_W  = ANG_W + RAT_W;

	// Divider layout: one quotient bit in the front stage, the rest two per stage
	localparam int DIV_SPS  = 2;
	localparam int DIV_STG  = Q_SHIFT / DIV_SPS;

	// Axis bearings
	localparam logic [ANG_W-1:0] BRG_NORTH = 16'h0000;
	localparam logic [ANG_W-1:0] BRG_EAST  = 16'h4000;
	localparam logic [ANG_W-1:0] BRG_SOUTH = 16'h8000;
	localparam logic [ANG_W-1:0] BRG_WEST  = 16'hC000;

	// Octant polynomial coefficients
	localparam logic [RAT_W-1:0] POLY_MID  = 15'h1333;
	localparam logic [K2_W-1:0]  POLY_K2   = 12'hB00;
	localparam logic [ANG_W-1:0] POLY_K1   = 16'h2800;
	localparam logic [RAT_W-1:0] RATIO_MAX = 15'h4000;
	localparam logic [ANG_W-1:0] ANG_MAX   = 16'h2800;

	// Control that rides along with each word
	typedef struct packed {
		logic             spec;
		logic [ANG_W-1:0] spec_brg;
		logic             swp;
		logic             xneg;
		logic             yneg;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bfd_div_stage.sv =====
`default_nettype none

module bfd_div_stage import bfd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             load,
	input  wire logic [MAG_W-1:0] rem_prev,
	input  wire logic [RAT_W-1:0] quo_prev,
	input  wire logic [MAG_W-1:0] hi_prev,
	output logic      [MAG_W-1:0] rem,
	output logic      [RAT_W-1:0] quo,
	output logic      [MAG_W-1:0] hi
);

	logic [MAG_W-1:0] rem_nxt;
	logic [RAT_W-1:0] quo_nxt;

	// Restoring division: shift, trial subtract, keep if non-negative
	always_comb begin
		logic [MAG_W:0] sh;
		logic           qbit;
		rem_nxt = rem_prev;
		quo_nxt = quo_prev;
		for (int j = 0; j < DIV_SPS; j++) begin
			sh   = {rem_nxt, 1'b0};
			qbit = (sh >= {1'b0, hi_prev});
			if (qbit) begin
				rem_nxt = MAG_W'(sh - {1'b0, hi_prev});
			end else begin
				rem_nxt = MAG_W'(sh);
			end
			quo_nxt = {quo_nxt[RAT_W-2:0], qbit};
		end
	end

	// Stage register
	always_ff @(posedge clk) begin
		if (load) begin
			rem <= rem_nxt;
			quo <= quo_nxt;
			hi  <= hi_prev;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bearing_from_deltas.sv =====
// Stages from accepted input word to output word (1 magnitude stage,
// 7 divider stages at two quotient bits each, 2 polynomial stages,
// 1 octant fold stage). Throughput: one word per cycle unless the output stalls;
// a stalled output lets empty stages behind it keep filling.
// The per-stage ready chain sets the stall behavior; nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears the stage valid bits only; no state is kept.
`default_nettype none

module bearing_from_deltas import bfd_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [DELTA_W-1:0] delta_x,
	input  wire logic signed [DELTA_W-1:0] delta_y,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic             [ANG_W-1:0]   bearing
);

	localparam int DIV_END = DIV_STG + 1;
	localparam int P1      = DIV_END + 1;
	localparam int P2      = DIV_END + 2;
	localparam int N_STG   = DIV_END + 3;

	logic v_s    [1:N_STG];
	logic load   [1:N_STG+1];
	ctl_t ctl_s  [1:P2];

	logic [MAG_W-1:0] rem_s [1:DIV_END];
	logic [RAT_W-1:0] quo_s [1:DIV_END];
	logic [MAG_W-1:0] hi_s  [1:DIV_END];

	logic [RAT_W-1:0]   r_s9;
	logic [PROD1_W-1:0] prod1_s9;
	logic [PROD2_W-1:0] prod2_s10;
	logic [ANG_W-1:0]   bearing_s11;

	// Ready chain: a stage loads when empty or when the one ahead moves
	always_comb begin
		load[N_STG+1] = out_ready;
		for (int i = N_STG; i >= 1; i--) begin
			load[i] = !v_s[i] || load[i+1];
		end
	end

	assign in_ready  = load[1];
	assign out_valid = v_s[N_STG];
	assign bearing   = bearing_s11;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= N_STG; i++) begin
				v_s[i] <= 1'b0;
			end
		end else begin
			if (load[1]) begin
				v_s[1] <= in_valid;
			end
			for (int i = 2; i <= N_STG; i++) begin
				if (load[i]) begin
					v_s[i] <= v_s[i-1];
				end
			end
		end
	end

	// Stage 1: magnitudes, order, axis cases, first quotient bit
	logic [MAG_W-1:0] xu, yu, ax, ay, lo, hi;
	logic             swp, eq;
	ctl_t             ctl_in;

	assign xu = delta_x;
	assign yu = delta_y;

	always_comb begin
		ax  = xu[MAG_W-1] ? MAG_W'(~xu + 16'd1) : xu;
		ay  = yu[MAG_W-1] ? MAG_W'(~yu + 16'd1) : yu;
		swp = ax > ay;
		lo  = swp ? ay : ax;
		hi  = swp ? ax : ay;
		eq  = lo == hi;

		ctl_in.swp      = swp;
		ctl_in.xneg     = xu[MAG_W-1];
		ctl_in.yneg     = yu[MAG_W-1];
		ctl_in.spec     = 1'b0;
		ctl_in.spec_brg = BRG_SOUTH;
		if (delta_x == 0) begin
			ctl_in.spec     = 1'b1;
			ctl_in.spec_brg = (delta_y > 0) ? BRG_NORTH : BRG_SOUTH;
		end else if (delta_y == 0) begin
			ctl_in.spec     = 1'b1;
			ctl_in.spec_brg = (delta_x > 0) ? BRG_EAST : BRG_WEST;
		end
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			rem_s[1] <= eq ? '0 : lo;
			quo_s[1] <= RAT_W'(eq);
			hi_s[1]  <= hi;
		end
	end

	// Control travels with its word
	always_ff @(posedge clk) begin
		if (load[1]) begin
			ctl_s[1] <= ctl_in;
		end
		for (int i = 2; i <= P2; i++) begin
			if (load[i]) begin
				ctl_s[i] <= ctl_s[i-1];
			end
		end
	end

	// Divider stages
	for (genvar k = 0; k < DIV_STG; k++) begin : g_div
		bfd_div_stage u_stage (
			.clk      (clk),
			.load     (load[k+2]),
			.rem_prev (rem_s[k+1]),
			.quo_prev (quo_s[k+1]),
			.hi_prev  (hi_s[k+1]),
			.rem      (rem_s[k+2]),
			.quo      (quo_s[k+2]),
			.hi       (hi_s[k+2])
		);
	end

	// First polynomial stage: distance from the midpoint times K2
	logic [RAT_W-1:0] mid_dist;

	always_comb begin
		if (quo_s[DIV_END] > POLY_MID) begin
			mid_dist = quo_s[DIV_END] - POLY_MID;
		end else begin
			mid_dist = POLY_MID - quo_s[DIV_END];
		end
	end

	always_ff @(posedge clk) begin
		if (load[P1]) begin
			r_s9     <= quo_s[DIV_END];
			prod1_s9 <= PROD1_W'(mid_dist) * PROD1_W'(POLY_K2);
		end
	end

	// Second polynomial stage: corrected slope times ratio
	logic [ANG_W-1:0] slope;

	assign slope = POLY_K1 - ANG_W'(prod1_s9[PROD1_W-1:Q_SHIFT]);

	always_ff @(posedge clk) begin
		if (load[P2]) begin
			prod2_s10 <= PROD2_W'(slope) * PROD2_W'(r_s9);
		end
	end

	// Output stage: fold the octant angle into place
	logic [ANG_W-1:0] ang, res;
	ctl_t             c10;

	assign ang = ANG_W'(prod2_s10[PROD2_W-1:Q_SHIFT]);
	assign c10 = ctl_s[P2];

	always_comb begin
		if (!c10.xneg) begin
			if (!c10.yneg) begin
				res = c10.swp ? BRG_EAST - ang : ang;
			end else begin
				res = c10.swp ? BRG_EAST + ang : BRG_SOUTH - ang;
			end
		end else begin
			if (!c10.yneg) begin
				res = c10.swp ? BRG_WEST + ang : BRG_NORTH - ang;
			end else begin
				res = c10.swp ? BRG_WEST - ang : BRG_SOUTH + ang;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[N_STG]) begin
			bearing_s11 <= c10.spec ? c10.spec_brg : res;
		end
	end

`ifndef SYNTHESIS
	// Quotient of an ordered pair never exceeds one in Q14
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[DIV_END] && !ctl_s[DIV_END].spec |-> quo_s[DIV_END] <= RATIO_MAX)
		else $error("ratio out of range");

	// Final remainder stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[DIV_END] && !ctl_s[DIV_END].spec |-> rem_s[DIV_END] < hi_s[DIV_END])
		else $error("divider remainder not reduced");

	// Octant angle never exceeds its bound
	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[P2] && !ctl_s[P2].spec |-> ang <= ANG_MAX)
		else $error("octant angle out of range");

	// A word held at the output blocks the stage behind it only when that stage is full
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> load[N_STG-1] == !v_s[N_STG-1])
		else $error("ready chain broken at output");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_bearing_from_deltas.sv =====
`default_nettype none

module tb_bearing_from_deltas;
	import bfd_pkg::*;

	localparam int RAND_WORDS   = 1400;
	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 60;
	localparam int HOLD_AFTER   = 300;
	localparam int N_DIR        = 23;

	// Scoreboard: predicts each bearing and checks results in order
	class bearing_scoreboard;
		logic [ANG_W-1:0] bearing_q[$];
		int errors;
		int n_noted;

		function logic [ANG_W-1:0] predict_bearing(logic signed [DELTA_W-1:0] dx,
				logic signed [DELTA_W-1:0] dy);
			int ax, ay, lo, hi, r, d, corr, a;
			logic [ANG_W-1:0] a16;
			bit swp;
			// axis cases
			if (dx == 0)
				return (dy > 0) ? BRG_NORTH : BRG_SOUTH;
			if (dy == 0)
				return (dx > 0) ? BRG_EAST : BRG_WEST;
			ax = (dx < 0) ? -int'(dx) : int'(dx);
			ay = (dy < 0) ? -int'(dy) : int'(dy);
			// ratio of smaller to larger magnitude, Q14
			swp = ax > ay;
			lo = swp ? ay : ax;
			hi = swp ? ax : ay;
			r = (lo << Q_SHIFT) / hi;
			// quadratic-corrected octant angle
			d = (r > int'(POLY_MID)) ? r - int'(POLY_MID) : int'(POLY_MID) - r;
			corr = (d * int'(POLY_K2)) >> Q_SHIFT;
			a = ((int'(POLY_K1) - corr) * r) >> Q_SHIFT;
			a16 = 16'(a);
			// fold into the octant
			if (dx > 0) begin
				if (dy > 0)
					return swp ? BRG_EAST - a16 : a16;
				else
					return swp ? BRG_EAST + a16 : BRG_SOUTH - a16;
			end else begin
				if (dy > 0)
					return swp ? BRG_WEST + a16 : BRG_NORTH - a16;
				else
					return swp ? BRG_WEST - a16 : BRG_SOUTH + a16;
			end
		endfunction

		function void note_deltas(logic signed [DELTA_W-1:0] dx,
				logic signed [DELTA_W-1:0] dy);
			bearing_q.push_back(predict_bearing(dx, dy));
			n_noted++;
		endfunction

		function void check_bearing(logic [ANG_W-1:0] got);
			logic [ANG_W-1:0] want;
			if (bearing_q.size() == 0) begin
				$error("bearing: no word expected, actual %h", got);
				errors++;
				return;
			end
			want = bearing_q.pop_front();
			if (got !== want) begin
				$error("bearing: expected %h, actual %h", want, got);
				errors++;
			end
		endfunction
	endclass

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic signed [DELTA_W-1:0]   delta_x   = '0;
	logic signed [DELTA_W-1:0]   delta_y   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic        [ANG_W-1:0]     bearing;

	bearing_scoreboard sb = new();
	bit quiet;
	int hold_left;
	bit hold_done;
	int stall_cycles;

	// directed deltas: axes, extremes, equal magnitudes, every octant but x < 0, y > 0, |x| > |y|
	int dir_x [N_DIR] = '{0, 0, 0, 1, -1, 0, 0, 32767, -32767, 32767, -32767, 32767,
		-32767, 1, 32767, -1, -32767, 100, -5, 12345, 1, 2, 21845};
	int dir_y [N_DIR] = '{0, 1, -1, 0, 0, 32767, -32767, 0, 0, 32767, -32767, -32767,
		32767, 32767, 1, -32767, -1, 100, 5, -23456, 2, 1, -10922};

	bearing_from_deltas u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bearing   (bearing)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int rand_delta();
		return int'($urandom_range(65534)) - 32767;
	endfunction

	// Offer one word, with random idle cycles ahead of it outside the quiet stretch
	task automatic send_word(int dx, int dy);
		while (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		delta_x  <= dx[DELTA_W-1:0];
		delta_y  <= dy[DELTA_W-1:0];
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_deltas(dx[DELTA_W-1:0], dy[DELTA_W-1:0]);
	endtask

	// Receiver: check accepted words, then pick next ready
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_bearing(bearing);
		if (!hold_done && sb.n_noted >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int dx, dy, sel;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_word(dir_x[i], dir_y[i]);

		for (int i = 0; i < RAND_WORDS; i++) begin
			quiet = (i >= 700 && i < 1000);
			sel = $urandom_range(99);
			dx = rand_delta();
			dy = rand_delta();
			if (sel < 5) begin
				dx = 0;
			end else if (sel < 10) begin
				dy = 0;
			end else if (sel < 20) begin
				// small magnitudes, zeros included
				dx = int'($urandom_range(16)) - 8;
				dy = int'($urandom_range(16)) - 8;
			end else if (sel < 28) begin
				dy = $urandom_range(1) ? dx : -dx;
			end else if (sel < 33) begin
				dx = $urandom_range(1) ? ($urandom_range(1) ? 32767 : -32767) : dx;
				dy = $urandom_range(1) ? ($urandom_range(1) ? 1 : -1) : dy;
				if ($urandom_range(1)) begin
					sel = dx;
					dx = dy;
					dy = sel;
				end
			end
			send_word(dx, dy);
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		// drain the pipeline
		while (sb.bearing_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.bearing_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bfd_pkg.sv
rtl/bfd_div_stage.sv
rtl/bearing_from_deltas.sv
bench/tb_bearing_from_deltas.sv
